>>> sv/mlc_pkg.sv
`timescale 1ns / 1ps

package mlc_pkg;

    // Default coordinate width
    localparam int COORD_BITS_DEF = 12;

    // Entries in the queue between classifier and bisection engine
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_X_MIN = 2'd0,
        REG_Y_MIN = 2'd1,
        REG_X_MAX = 2'd2,
        REG_Y_MAX = 2'd3
    } cfg_reg_t;

    // Window reset values, before fitting to the coordinate width
    localparam longint WIN_X_MIN_RST = 0;
    localparam longint WIN_Y_MIN_RST = 0;
    localparam longint WIN_X_MAX_RST = 200;
    localparam longint WIN_Y_MAX_RST = 120;

    // Outcode bits
    localparam logic [3:0] OC_LEFT  = 4'b0001;
    localparam logic [3:0] OC_RIGHT = 4'b0010;
    localparam logic [3:0] OC_BELOW = 4'b0100;
    localparam logic [3:0] OC_ABOVE = 4'b1000;
    localparam logic [3:0] OC_INSIDE = 4'b0000;

    // Segment class decided by the classifier
    localparam int CLS_BITS = 3;

    typedef enum logic [CLS_BITS-1:0] {
        CLS_ACCEPT     = 3'd0,
        CLS_REJECT     = 3'd1,
        CLS_SEEK_END   = 3'd2,
        CLS_SEEK_START = 3'd3,
        CLS_BOTH_OUT   = 3'd4
    } seg_class_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> sv/mlc_front.sv
`timescale 1ns / 1ps

module mlc_front
    import mlc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [COORD_BITS-1:0]          a_x,
    input  logic signed [COORD_BITS-1:0]          a_y,
    input  logic signed [COORD_BITS-1:0]          b_x,
    input  logic signed [COORD_BITS-1:0]          b_y,
    input  logic signed [COORD_BITS-1:0]          win_x_min,
    input  logic signed [COORD_BITS-1:0]          win_y_min,
    input  logic signed [COORD_BITS-1:0]          win_x_max,
    input  logic signed [COORD_BITS-1:0]          win_y_max,
    input  q_stat_t                               q_stat,
    output logic                                  push,
    output logic [4*COORD_BITS+CLS_BITS-1:0]      push_data
);

    function automatic logic [3:0] outcode(
        input logic signed [COORD_BITS-1:0] px,
        input logic signed [COORD_BITS-1:0] py,
        input logic signed [COORD_BITS-1:0] xmin,
        input logic signed [COORD_BITS-1:0] ymin,
        input logic signed [COORD_BITS-1:0] xmax,
        input logic signed [COORD_BITS-1:0] ymax
    );
        logic [3:0] c;
        c = OC_INSIDE;
        if (px < xmin) c = c | OC_LEFT;
        if (px > xmax) c = c | OC_RIGHT;
        if (py < ymin) c = c | OC_BELOW;
        if (py > ymax) c = c | OC_ABOVE;
        return c;
    endfunction

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [COORD_BITS-1:0]  a_x_reg;
    logic signed [COORD_BITS-1:0]  a_y_reg;
    logic signed [COORD_BITS-1:0]  b_x_reg;
    logic signed [COORD_BITS-1:0]  b_y_reg;
    logic                          accept;
    logic [3:0]                    code_a;
    logic [3:0]                    code_b;
    seg_class_t                    cls;

    // Hold one transaction until the queue takes it
    assign push       = valid_reg && !q_stat.full;
    assign busy       = valid_reg && q_stat.full;
    assign accept     = start && !busy;
    assign valid_next = accept || (valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the segment
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg <= a_x;
            a_y_reg <= a_y;
            b_x_reg <= b_x;
            b_y_reg <= b_y;
        end
    end

    // Classify by outcodes
    always_comb
    begin
        code_a = outcode(a_x_reg, a_y_reg, win_x_min, win_y_min, win_x_max, win_y_max);
        code_b = outcode(b_x_reg, b_y_reg, win_x_min, win_y_min, win_x_max, win_y_max);
        priority if ((code_a | code_b) == OC_INSIDE)
        begin
            cls = CLS_ACCEPT;
        end
        else if ((code_a & code_b) != OC_INSIDE)
        begin
            cls = CLS_REJECT;
        end
        else if (code_a == OC_INSIDE)
        begin
            cls = CLS_SEEK_END;
        end
        else if (code_b == OC_INSIDE)
        begin
            cls = CLS_SEEK_START;
        end
        else
        begin
            cls = CLS_BOTH_OUT;
        end
    end

    assign push_data = {cls, a_x_reg, a_y_reg, b_x_reg, b_y_reg};

endmodule

>>> sv/mlc_queue.sv
`timescale 1ns / 1ps

module mlc_queue
    import mlc_pkg::*;
#(
    parameter int WIDTH = 4*COORD_BITS_DEF+CLS_BITS,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_stat_t          q_stat
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign q_stat.full  = (count_reg == CNT_BITS'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the transaction
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];

endmodule

>>> sv/mlc_back.sv
`timescale 1ns / 1ps

module mlc_back
    import mlc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [4*COORD_BITS+CLS_BITS-1:0]      pop_data,
    input  q_stat_t                               q_stat,
    output logic                                  pop,
    input  logic signed [COORD_BITS-1:0]          win_x_min,
    input  logic signed [COORD_BITS-1:0]          win_y_min,
    input  logic signed [COORD_BITS-1:0]          win_x_max,
    input  logic signed [COORD_BITS-1:0]          win_y_max,
    output logic                                  done,
    output logic                                  visible,
    output logic signed [COORD_BITS-1:0]          start_x,
    output logic signed [COORD_BITS-1:0]          start_y,
    output logic signed [COORD_BITS-1:0]          end_x,
    output logic signed [COORD_BITS-1:0]          end_y
);

    localparam int N = COORD_BITS;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SEEK_S = 4'b0100,
        ST_SEEK_E = 4'b1000
    } state_t;

    function automatic logic [3:0] outcode(
        input logic signed [N-1:0] px,
        input logic signed [N-1:0] py,
        input logic signed [N-1:0] xmin,
        input logic signed [N-1:0] ymin,
        input logic signed [N-1:0] xmax,
        input logic signed [N-1:0] ymax
    );
        logic [3:0] c;
        c = OC_INSIDE;
        if (px < xmin) c = c | OC_LEFT;
        if (px > xmax) c = c | OC_RIGHT;
        if (py < ymin) c = c | OC_BELOW;
        if (py > ymax) c = c | OC_ABOVE;
        return c;
    endfunction

    state_t               state_reg, state_next;
    logic signed [N-1:0]  in_x_reg, in_x_next, in_y_reg, in_y_next;
    logic signed [N-1:0]  out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic signed [N-1:0]  km_x_reg, km_x_next, km_y_reg, km_y_next;
    logic signed [N-1:0]  kq_x_reg, kq_x_next, kq_y_reg, kq_y_next;
    logic signed [N-1:0]  s_x_reg, s_x_next, s_y_reg, s_y_next;
    logic signed [N-1:0]  e_x_reg, e_x_next, e_y_reg, e_y_next;
    logic                 two_reg, two_next;
    logic                 done_reg, done_next;
    logic                 vis_reg, vis_next;
    logic signed [N-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic signed [N-1:0]  ex_reg, ex_next, ey_reg, ey_next;

    seg_class_t           cls;
    logic signed [N-1:0]  q_a_x, q_a_y, q_b_x, q_b_y;
    logic signed [N:0]    sum_x, sum_y, adj_x, adj_y;
    logic signed [N-1:0]  mid_x, mid_y;
    logic signed [N:0]    dx, dy;
    logic [N:0]           abs_x, abs_y;
    logic [N+1:0]         man_dist;
    logic                 far;
    logic [3:0]           oc_m;
    logic [3:0]           oc_p;

    // Unpack the queue head
    assign cls   = seg_class_t'(pop_data[4*N+CLS_BITS-1 -: CLS_BITS]);
    assign q_a_x = pop_data[4*N-1 -: N];
    assign q_a_y = pop_data[3*N-1 -: N];
    assign q_b_x = pop_data[2*N-1 -: N];
    assign q_b_y = pop_data[N-1 -: N];

    // Shared halving unit: midpoint toward zero, distance, outcodes
    always_comb
    begin
        sum_x    = {in_x_reg[N-1], in_x_reg} + {out_x_reg[N-1], out_x_reg};
        sum_y    = {in_y_reg[N-1], in_y_reg} + {out_y_reg[N-1], out_y_reg};
        adj_x    = sum_x + {{N{1'b0}}, sum_x[N]};
        adj_y    = sum_y + {{N{1'b0}}, sum_y[N]};
        mid_x    = adj_x[N:1];
        mid_y    = adj_y[N:1];
        dx       = {in_x_reg[N-1], in_x_reg} - {out_x_reg[N-1], out_x_reg};
        dy       = {in_y_reg[N-1], in_y_reg} - {out_y_reg[N-1], out_y_reg};
        abs_x    = dx[N] ? $unsigned(-dx) : $unsigned(dx);
        abs_y    = dy[N] ? $unsigned(-dy) : $unsigned(dy);
        man_dist = {1'b0, abs_x} + {1'b0, abs_y};
        far      = (man_dist > (N+2)'(2));
        oc_m     = outcode(mid_x, mid_y, win_x_min, win_y_min, win_x_max, win_y_max);
        oc_p     = outcode(in_x_reg, in_y_reg, win_x_min, win_y_min, win_x_max, win_y_max);
    end

    // Sequence the searches
    always_comb
    begin
        state_next = state_reg;
        in_x_next  = in_x_reg;
        in_y_next  = in_y_reg;
        out_x_next = out_x_reg;
        out_y_next = out_y_reg;
        km_x_next  = km_x_reg;
        km_y_next  = km_y_reg;
        kq_x_next  = kq_x_reg;
        kq_y_next  = kq_y_reg;
        s_x_next   = s_x_reg;
        s_y_next   = s_y_reg;
        e_x_next   = e_x_reg;
        e_y_next   = e_y_reg;
        two_next   = two_reg;
        done_next  = 1'b0;
        vis_next   = vis_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    unique case (cls)
                        CLS_ACCEPT:
                        begin
                            done_next = 1'b1;
                            vis_next  = 1'b1;
                            sx_next   = q_a_x;
                            sy_next   = q_a_y;
                            ex_next   = q_b_x;
                            ey_next   = q_b_y;
                        end
                        CLS_SEEK_END:
                        begin
                            s_x_next   = q_a_x;
                            s_y_next   = q_a_y;
                            in_x_next  = q_a_x;
                            in_y_next  = q_a_y;
                            out_x_next = q_b_x;
                            out_y_next = q_b_y;
                            two_next   = 1'b0;
                            state_next = ST_SEEK_E;
                        end
                        CLS_SEEK_START:
                        begin
                            e_x_next   = q_b_x;
                            e_y_next   = q_b_y;
                            in_x_next  = q_b_x;
                            in_y_next  = q_b_y;
                            out_x_next = q_a_x;
                            out_y_next = q_a_y;
                            two_next   = 1'b0;
                            state_next = ST_SEEK_S;
                        end
                        CLS_BOTH_OUT:
                        begin
                            in_x_next  = q_a_x;
                            in_y_next  = q_a_y;
                            out_x_next = q_b_x;
                            out_y_next = q_b_y;
                            state_next = ST_SEARCH;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            vis_next  = 1'b0;
                            sx_next   = '0;
                            sy_next   = '0;
                            ex_next   = '0;
                            ey_next   = '0;
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                // in holds p, out holds q
                if ((oc_m != OC_INSIDE) && far)
                begin
                    if ((oc_p & oc_m) != OC_INSIDE)
                    begin
                        in_x_next = mid_x;
                        in_y_next = mid_y;
                    end
                    else
                    begin
                        out_x_next = mid_x;
                        out_y_next = mid_y;
                    end
                end
                else if (oc_m == OC_INSIDE)
                begin
                    km_x_next  = mid_x;
                    km_y_next  = mid_y;
                    kq_x_next  = out_x_reg;
                    kq_y_next  = out_y_reg;
                    in_x_next  = mid_x;
                    in_y_next  = mid_y;
                    out_x_next = in_x_reg;
                    out_y_next = in_y_reg;
                    two_next   = 1'b1;
                    state_next = ST_SEEK_S;
                end
                else
                begin
                    done_next  = 1'b1;
                    vis_next   = 1'b0;
                    sx_next    = '0;
                    sy_next    = '0;
                    ex_next    = '0;
                    ey_next    = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_SEEK_S:
            begin
                if (far)
                begin
                    if (oc_m == OC_INSIDE)
                    begin
                        in_x_next = mid_x;
                        in_y_next = mid_y;
                    end
                    else
                    begin
                        out_x_next = mid_x;
                        out_y_next = mid_y;
                    end
                end
                else if (two_reg)
                begin
                    s_x_next   = in_x_reg;
                    s_y_next   = in_y_reg;
                    in_x_next  = km_x_reg;
                    in_y_next  = km_y_reg;
                    out_x_next = kq_x_reg;
                    out_y_next = kq_y_reg;
                    state_next = ST_SEEK_E;
                end
                else
                begin
                    done_next  = 1'b1;
                    vis_next   = 1'b1;
                    sx_next    = in_x_reg;
                    sy_next    = in_y_reg;
                    ex_next    = e_x_reg;
                    ey_next    = e_y_reg;
                    state_next = ST_IDLE;
                end
            end

            ST_SEEK_E:
            begin
                if (far)
                begin
                    if (oc_m == OC_INSIDE)
                    begin
                        in_x_next = mid_x;
                        in_y_next = mid_y;
                    end
                    else
                    begin
                        out_x_next = mid_x;
                        out_y_next = mid_y;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    vis_next   = 1'b1;
                    sx_next    = s_x_reg;
                    sy_next    = s_y_reg;
                    ex_next    = in_x_reg;
                    ey_next    = in_y_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Working points and result fields
    always_ff @(posedge clk)
    begin
        in_x_reg  <= in_x_next;
        in_y_reg  <= in_y_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        km_x_reg  <= km_x_next;
        km_y_reg  <= km_y_next;
        kq_x_reg  <= kq_x_next;
        kq_y_reg  <= kq_y_next;
        s_x_reg   <= s_x_next;
        s_y_reg   <= s_y_next;
        e_x_reg   <= e_x_next;
        e_y_reg   <= e_y_next;
        two_reg   <= two_next;
        vis_reg   <= vis_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
    end

    assign done    = done_reg;
    assign visible = vis_reg;
    assign start_x = sx_reg;
    assign start_y = sy_reg;
    assign end_x   = ex_reg;
    assign end_y   = ey_reg;

endmodule

>>> sv/midpoint_line_clipper.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake               Payload
// segment    in         start high, busy low    a_x, a_y, b_x, b_y
// result     out        done strobe, one cycle  visible, start_x, start_y, end_x, end_y
// window     in         wr_en high              wr_index, wr_data
//
// A segment is held in the classifier register, then waits in a
// two-entry queue for the bisection engine. Trivially accepted or rejected
// segments are finished in the idle state; otherwise up to three searches
// run on the one shared halving unit, one halving per cycle. busy rises
// only while the classifier holds a transaction and the queue is full.
// Reset clears control and loads the default window; results cannot be
// held off by the receiver.

module midpoint_line_clipper
    import mlc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  a_x,
    input  logic signed [COORD_BITS-1:0]  a_y,
    input  logic signed [COORD_BITS-1:0]  b_x,
    input  logic signed [COORD_BITS-1:0]  b_y,
    input  logic                          wr_en,
    input  logic [CFG_IDX_BITS-1:0]       wr_index,
    input  logic [COORD_BITS-1:0]         wr_data,
    output logic                          done,
    output logic                          visible,
    output logic signed [COORD_BITS-1:0]  start_x,
    output logic signed [COORD_BITS-1:0]  start_y,
    output logic signed [COORD_BITS-1:0]  end_x,
    output logic signed [COORD_BITS-1:0]  end_y
);

    localparam int     ENTRY_BITS = 4*COORD_BITS + CLS_BITS;
    localparam longint POS_MAX    = (longint'(1) <<< (COORD_BITS - 1)) - 1;

    // Defaults that exceed a narrow coordinate range saturate; same outcodes
    localparam logic signed [COORD_BITS-1:0] X_MIN_RST =
        COORD_BITS'((WIN_X_MIN_RST > POS_MAX) ? POS_MAX : WIN_X_MIN_RST);
    localparam logic signed [COORD_BITS-1:0] Y_MIN_RST =
        COORD_BITS'((WIN_Y_MIN_RST > POS_MAX) ? POS_MAX : WIN_Y_MIN_RST);
    localparam logic signed [COORD_BITS-1:0] X_MAX_RST =
        COORD_BITS'((WIN_X_MAX_RST > POS_MAX) ? POS_MAX : WIN_X_MAX_RST);
    localparam logic signed [COORD_BITS-1:0] Y_MAX_RST =
        COORD_BITS'((WIN_Y_MAX_RST > POS_MAX) ? POS_MAX : WIN_Y_MAX_RST);

    logic signed [COORD_BITS-1:0] win_x_min_reg;
    logic signed [COORD_BITS-1:0] win_y_min_reg;
    logic signed [COORD_BITS-1:0] win_x_max_reg;
    logic signed [COORD_BITS-1:0] win_y_max_reg;
    logic                         push;
    logic                         pop;
    logic [ENTRY_BITS-1:0]        push_data;
    logic [ENTRY_BITS-1:0]        pop_data;
    q_stat_t                      q_stat;

    // Write window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_min_reg <= X_MIN_RST;
            win_y_min_reg <= Y_MIN_RST;
            win_x_max_reg <= X_MAX_RST;
            win_y_max_reg <= Y_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_reg_t'(wr_index))
                REG_X_MIN: win_x_min_reg <= wr_data;
                REG_Y_MIN: win_y_min_reg <= wr_data;
                REG_X_MAX: win_x_max_reg <= wr_data;
                REG_Y_MAX: win_y_max_reg <= wr_data;
            endcase
        end
    end

    mlc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .a_x       (a_x),
        .a_y       (a_y),
        .b_x       (b_x),
        .b_y       (b_y),
        .win_x_min (win_x_min_reg),
        .win_y_min (win_y_min_reg),
        .win_x_max (win_x_max_reg),
        .win_y_max (win_y_max_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    mlc_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    mlc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (pop_data),
        .q_stat    (q_stat),
        .pop       (pop),
        .win_x_min (win_x_min_reg),
        .win_y_min (win_y_min_reg),
        .win_x_max (win_x_max_reg),
        .win_y_max (win_y_max_reg),
        .done      (done),
        .visible   (visible),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y)
    );

`ifndef SYNTHESIS
    // A rejected segment reports all-zero endpoints
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !visible) |->
            (start_x == '0 && start_y == '0 && end_x == '0 && end_y == '0))
        else $error("rejected segment with nonzero endpoints");

    // A visible segment's clipped endpoints lie inside the window
    a_visible_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (done && visible) |->
            (start_x >= win_x_min_reg && start_x <= win_x_max_reg &&
             start_y >= win_y_min_reg && start_y <= win_y_max_reg &&
             end_x >= win_x_min_reg && end_x <= win_x_max_reg &&
             end_y >= win_y_min_reg && end_y <= win_y_max_reg))
        else $error("visible endpoint outside window");

    // While busy, the queue is never pushed and popped in the same cycle
    a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !(push && pop))
        else $error("busy while queue moves both ways");
`endif

endmodule

>>> tb/midpoint_line_clipper_tb.sv
`timescale 1ns / 1ps

module midpoint_line_clipper_tb;
    import mlc_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int C_MIN = -(1 << (CW - 1));
    localparam int C_MAX = (1 << (CW - 1)) - 1;
    // Worst case of three searches on the shared halving unit, with margin
    localparam int SETTLE_CYCLES = 3 * (CW + 2) + 20;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct {
        longint x;
        longint y;
    } coord_pt_t;

    typedef struct {
        logic                  visible;
        logic signed [CW-1:0]  sx;
        logic signed [CW-1:0]  sy;
        logic signed [CW-1:0]  ex;
        logic signed [CW-1:0]  ey;
    } clip_t;

    // Track the window, predict each clipped segment and check results in order
    class clip_scoreboard;
        longint x_min;
        longint y_min;
        longint x_max;
        longint y_max;
        clip_t  expected_clips[$];
        int     mismatches;
        int     checked;
        int     noted;

        function new();
            x_min = WIN_X_MIN_RST;
            y_min = WIN_Y_MIN_RST;
            x_max = WIN_X_MAX_RST;
            y_max = WIN_Y_MAX_RST;
            mismatches = 0;
            checked = 0;
            noted = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic signed [CW-1:0] value);
            longint v;
            v = longint'(value);
            case (idx)
                REG_X_MIN: x_min = v;
                REG_Y_MIN: y_min = v;
                REG_X_MAX: x_max = v;
                REG_Y_MAX: y_max = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_clips.size();
        endfunction

        function logic [3:0] region_code(coord_pt_t p);
            logic [3:0] c;
            c = OC_INSIDE;
            if (p.x < x_min) c |= OC_LEFT;
            if (p.x > x_max) c |= OC_RIGHT;
            if (p.y < y_min) c |= OC_BELOW;
            if (p.y > y_max) c |= OC_ABOVE;
            return c;
        endfunction

        function longint manhattan(coord_pt_t p, coord_pt_t q);
            longint dx;
            longint dy;
            dx = p.x - q.x;
            dy = p.y - q.y;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            return dx + dy;
        endfunction

        // Integer division truncates toward zero, as the block does
        function coord_pt_t halfway(coord_pt_t p, coord_pt_t q);
            coord_pt_t m;
            m.x = (p.x + q.x) / 2;
            m.y = (p.y + q.y) / 2;
            return m;
        endfunction

        // Bisect from an inside point toward an outside one; keep the last inside point
        function coord_pt_t seek_boundary(coord_pt_t inner, coord_pt_t outer);
            coord_pt_t m;
            while (manhattan(inner, outer) > 2) begin
                m = halfway(inner, outer);
                if (region_code(m) == OC_INSIDE)
                    inner = m;
                else
                    outer = m;
            end
            return inner;
        endfunction

        function clip_t clip_segment(coord_pt_t a, coord_pt_t b);
            clip_t      r;
            coord_pt_t  s;
            coord_pt_t  e;
            coord_pt_t  p;
            coord_pt_t  q;
            coord_pt_t  m;
            logic [3:0] ca;
            logic [3:0] cb;
            logic       vis;
            ca = region_code(a);
            cb = region_code(b);
            s = a;
            e = b;
            vis = 1'b0;
            if ((ca | cb) == OC_INSIDE) begin
                vis = 1'b1;
            end
            else if ((ca & cb) != OC_INSIDE) begin
                vis = 1'b0;
            end
            else if (ca == OC_INSIDE) begin
                e = seek_boundary(a, b);
                vis = 1'b1;
            end
            else if (cb == OC_INSIDE) begin
                s = seek_boundary(b, a);
                vis = 1'b1;
            end
            else begin
                // Both ends outside: hunt for an inside midpoint first
                p = a;
                q = b;
                m = halfway(a, b);
                while (region_code(m) != OC_INSIDE && manhattan(p, q) > 2) begin
                    if ((region_code(p) & region_code(m)) != OC_INSIDE)
                        p = m;
                    else
                        q = m;
                    m = halfway(p, q);
                end
                if (region_code(m) == OC_INSIDE) begin
                    s = seek_boundary(m, p);
                    e = seek_boundary(m, q);
                    vis = 1'b1;
                end
            end
            r.visible = vis;
            r.sx = vis ? s.x[CW-1:0] : '0;
            r.sy = vis ? s.y[CW-1:0] : '0;
            r.ex = vis ? e.x[CW-1:0] : '0;
            r.ey = vis ? e.y[CW-1:0] : '0;
            return r;
        endfunction

        function void note_segment(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                   logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
            coord_pt_t a;
            coord_pt_t b;
            a.x = longint'(ax);
            a.y = longint'(ay);
            b.x = longint'(bx);
            b.y = longint'(by);
            expected_clips.push_back(clip_segment(a, b));
            noted++;
        endfunction

        function void check_result(logic vis, logic signed [CW-1:0] sx,
                                   logic signed [CW-1:0] sy, logic signed [CW-1:0] ex,
                                   logic signed [CW-1:0] ey);
            clip_t x;
            if (expected_clips.size() == 0) begin
                $error("result with no segment outstanding: visible %0b", vis);
                mismatches++;
                return;
            end
            x = expected_clips.pop_front();
            checked++;
            if (vis !== x.visible) begin
                $error("visible: expected %0d, got %0d", x.visible, vis);
                mismatches++;
            end
            if (sx !== x.sx) begin
                $error("start_x: expected %0d, got %0d", x.sx, sx);
                mismatches++;
            end
            if (sy !== x.sy) begin
                $error("start_y: expected %0d, got %0d", x.sy, sy);
                mismatches++;
            end
            if (ex !== x.ex) begin
                $error("end_x: expected %0d, got %0d", x.ex, ex);
                mismatches++;
            end
            if (ey !== x.ey) begin
                $error("end_y: expected %0d, got %0d", x.ey, ey);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic signed [CW-1:0]  a_x;
    logic signed [CW-1:0]  a_y;
    logic signed [CW-1:0]  b_x;
    logic signed [CW-1:0]  b_y;
    logic                  wr_en;
    logic [CFG_IDX_BITS-1:0] wr_index;
    logic [CW-1:0]         wr_data;
    logic                  done;
    logic                  visible;
    logic signed [CW-1:0]  start_x;
    logic signed [CW-1:0]  start_y;
    logic signed [CW-1:0]  end_x;
    logic signed [CW-1:0]  end_y;

    clip_scoreboard sb;
    bit gaps_on;
    bit stalled;
    int windows_used;

    midpoint_line_clipper #(
        .COORD_BITS (CW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .a_x      (a_x),
        .a_y      (a_y),
        .b_x      (b_x),
        .b_y      (b_y),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .done     (done),
        .visible  (visible),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Check every strobed result at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(visible, start_x, start_y, end_x, end_y);
    end

    // Hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int clamp_coord(int v);
        if (v < C_MIN) return C_MIN;
        if (v > C_MAX) return C_MAX;
        return v;
    endfunction

    function automatic int rand_between(int lo, int hi);
        int t;
        if (lo > hi) begin
            t = lo;
            lo = hi;
            hi = t;
        end
        lo = clamp_coord(lo);
        hi = clamp_coord(hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Pick one coordinate against a window edge pair: 0 anywhere, 1 inside,
    // 2 near the window, 3 on or next to an edge, 4 at the field extremes
    function automatic int pick_coord(int lo, int hi, int mode);
        int margin;
        case (mode)
            1: return rand_between(lo, hi);
            2: begin
                margin = $urandom_range(1, 300);
                return rand_between(lo - margin, hi + margin);
            end
            3: begin
                case ($urandom_range(0, 5))
                    0: return clamp_coord(lo - 1);
                    1: return clamp_coord(lo);
                    2: return clamp_coord(hi);
                    3: return clamp_coord(hi + 1);
                    4: return clamp_coord(lo - 2);
                    default: return clamp_coord(hi + 2);
                endcase
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return C_MIN + 1;
                    default: return C_MAX - 1;
                endcase
            end
            default: return rand_between(C_MIN, C_MAX);
        endcase
    endfunction

    // Drive one segment; called and returns at a falling edge
    task automatic send_segment(int ax, int ay, int bx, int by);
        if (gaps_on && $urandom_range(0, 99) < 9) begin
            start <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(4, 60)) @(negedge clk);
            else
                repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        start <= 1'b1;
        a_x <= ax[CW-1:0];
        a_y <= ay[CW-1:0];
        b_x <= bx[CW-1:0];
        b_y <= by[CW-1:0];
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_segment(ax[CW-1:0], ay[CW-1:0], bx[CW-1:0], by[CW-1:0]);
        @(negedge clk);
    endtask

    // Wait until every outstanding segment has come back, then let the engine settle
    task automatic drain();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            stalled = 1'b1;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int value);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value[CW-1:0];
        @(negedge clk);
        sb.set_reg(idx, value[CW-1:0]);
    endtask

    task automatic set_window(int xmin, int ymin, int xmax, int ymax);
        drain();
        write_reg(REG_X_MIN, xmin);
        write_reg(REG_Y_MIN, ymin);
        write_reg(REG_X_MAX, xmax);
        write_reg(REG_Y_MAX, ymax);
        wr_en <= 1'b0;
        @(negedge clk);
        windows_used++;
    endtask

    // Mostly segments with an end inside or near the window, some pure noise
    task automatic run_random(int count);
        int kind;
        int ma;
        int mb;
        int xl;
        int xh;
        int yl;
        int yh;
        xl = int'(sb.x_min);
        xh = int'(sb.x_max);
        yl = int'(sb.y_min);
        yh = int'(sb.y_max);
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                ma = 1;
                mb = $urandom_range(0, 4);
            end
            else if (kind < 50) begin
                ma = $urandom_range(0, 4);
                mb = 1;
            end
            else if (kind < 75) begin
                ma = 2;
                mb = 2;
            end
            else if (kind < 85) begin
                ma = 0;
                mb = 0;
            end
            else if (kind < 93) begin
                ma = 3;
                mb = 3;
            end
            else begin
                ma = 4;
                mb = $urandom_range(0, 1) ? 4 : 2;
            end
            send_segment(pick_coord(xl, xh, ma), pick_coord(yl, yh, ma),
                         pick_coord(xl, xh, mb), pick_coord(yl, yh, mb));
        end
    endtask

    initial
    begin
        int lo;
        int hi;
        int lo2;
        int hi2;
        sb = new();
        gaps_on = 1'b1;
        stalled = 1'b0;
        windows_used = 1;
        rst_n = 1'b0;
        start = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_X_MIN;
        wr_data = '0;
        a_x = '0;
        a_y = '0;
        b_x = '0;
        b_y = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed cases on the reset window
        send_segment(10, 10, 190, 110);          // accepted whole
        send_segment(0, 0, 200, 120);            // corner to corner
        send_segment(-50, 10, -10, 100);         // rejected, both left
        send_segment(C_MIN, C_MIN, C_MIN, C_MAX); // rejected at the field extreme
        send_segment(100, 60, C_MAX, 60);        // clip the far end
        send_segment(C_MIN, C_MIN, 100, 60);     // clip the near end
        send_segment(-100, 60, 300, 60);         // both outside, crosses
        send_segment(-50, 100, 50, 200);         // both outside, misses the corner
        send_segment(200, 60, 201, 61);          // short segment, inside end kept
        send_segment(201, 61, 200, 60);
        send_segment(-1, 0, 1, -1);              // midpoint truncates onto the window
        send_segment(-3, -3, 100, 60);
        send_segment(C_MAX, C_MAX, C_MIN, C_MIN);
        send_segment(C_MIN, C_MAX, C_MAX, C_MIN);
        send_segment(C_MAX, C_MIN, C_MIN, C_MAX);
        send_segment(100, C_MIN, 100, C_MAX);
        send_segment(-1, -1, -1, -1);
        send_segment(200, 120, 201, 121);
        run_random(280);

        // Whole coordinate range: everything is inside
        set_window(C_MIN, C_MIN, C_MAX, C_MAX);
        send_segment(C_MIN, C_MIN, C_MAX, C_MAX);
        run_random(150);

        // Small window around the origin, back to back with no gaps
        gaps_on = 1'b0;
        set_window(-20, -15, 20, 15);
        run_random(200);
        gaps_on = 1'b1;

        // Single point window
        lo = rand_between(-100, 100);
        hi = rand_between(-100, 100);
        set_window(lo, hi, lo, hi);
        send_segment(lo - 5, hi, lo + 5, hi);
        run_random(100);

        // Inverted window: nothing is ever visible
        set_window(50, 50, -50, -50);
        send_segment(0, 0, 10, 10);
        send_segment(C_MIN, C_MIN, C_MAX, C_MAX);
        run_random(100);

        // Random windows
        for (int w = 0; w < 5; w++) begin
            lo = rand_between(C_MIN, C_MAX);
            hi = rand_between(C_MIN, C_MAX);
            lo2 = rand_between(C_MIN, C_MAX);
            hi2 = rand_between(C_MIN, C_MAX);
            set_window(lo < hi ? lo : hi, lo2 < hi2 ? lo2 : hi2,
                       lo < hi ? hi : lo, lo2 < hi2 ? hi2 : lo2);
            run_random(220);
        end

        drain();
        $display("Sent %0d segments across %0d clip windows; %0d results checked, %0d mismatches",
                 sb.noted, windows_used, sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && !stalled)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
